// ----- src/rv32_register_file_alu_executor_assert.svh -----
// Assertion macros used by the executor's top-level RTL file.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RV32_REGISTER_FILE_ALU_EXECUTOR_ASSERT_SVH
`define RV32_REGISTER_FILE_ALU_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RVX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rvx_pkg.sv -----
// Shared types and codes for the RV32 register file and ALU executor.
// No dependencies; used by every module of the block.
package rvx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned SHAMT_W   = 5;
  localparam int unsigned LUI_SHIFT = 12;

  typedef enum logic [4:0] {
    FN_NOP   = 5'd0,
    FN_ADD   = 5'd1,
    FN_SUB   = 5'd2,
    FN_SLL   = 5'd3,
    FN_SLT   = 5'd4,
    FN_SLTU  = 5'd5,
    FN_XOR   = 5'd6,
    FN_SRL   = 5'd7,
    FN_SRA   = 5'd8,
    FN_OR    = 5'd9,
    FN_AND   = 5'd10,
    FN_MUL   = 5'd11,
    FN_ADDI  = 5'd12,
    FN_SLLI  = 5'd13,
    FN_SLTI  = 5'd14,
    FN_SLTIU = 5'd15,
    FN_XORI  = 5'd16,
    FN_SRLI  = 5'd17,
    FN_SRAI  = 5'd18,
    FN_ORI   = 5'd19,
    FN_ANDI  = 5'd20,
    FN_LUI   = 5'd21,
    FN_LI    = 5'd22,
    FN_MV    = 5'd23,
    FN_CLEAR = 5'd24
  } func_t;

  typedef struct packed {
    logic [4:0]        func;
    logic [REG_AW-1:0] dest_reg;
    logic [REG_AW-1:0] src_a_reg;
    logic [REG_AW-1:0] src_b_reg;
    logic signed [XLEN-1:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0] new_value;
    logic [XLEN-1:0] old_value;
    logic            written;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EXEC = 2'd2
  } state_t;

  // Register file access request for one cycle.
  typedef struct packed {
    logic              re0;
    logic              re1;
    logic [REG_AW-1:0] raddr0;
    logic [REG_AW-1:0] raddr1;
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [XLEN-1:0]   wdata;
    logic              clr;
  } rf_req_t;

endpackage

// ----- src/rv32_register_file_alu_executor.sv -----
// Top level of the RV32 integer executor: sequencer, output register, assertions.
// Depends on rvx_pkg, rvx_regfile, rvx_alu and the assertion macro header.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one operation per
//   transfer: function code, destination, two source registers and a 32-bit
//   immediate. The output channel (out_valid, out_ready, out_data) returns one
//   result per operation: the destination's new and previous value and a flag
//   that tells whether a nonzero destination was updated.
//   Each operation runs in steps: the first reads both source registers
//   from the register file, the second reads the destination's old value on the
//   same read port, the third runs the ALU, writes the register file and loads
//   the output register. The two-port synchronous register file sets these
//   steps, so the block takes a new transfer only after the last one has
//   finished its third step.
//   Reset clears the valid bits of all registers at once, so every register
//   reads zero right after reset; no clearing pass is needed. Clear-all does
//   the same.
//   When the receiver stalls, the result waits in the output register and the
//   next operation still enters and reads its operands; it holds in its last
//   step until the output register frees up, so nothing is lost or repeated.
module rv32_register_file_alu_executor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rvx_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rvx_pkg::out_item_t    out_data
);
  import rvx_pkg::*;

  `include "rv32_register_file_alu_executor_assert.svh"

  state_t          state_r;
  state_t          state_nxt;
  in_item_t        op_r;
  logic [XLEN-1:0] src_a_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  out_item_t       out_data_r;
  rf_req_t         rf_req;
  logic [XLEN-1:0] rdata0;
  logic [XLEN-1:0] rdata1;
  logic [XLEN-1:0] alu_res;
  logic            exec_go;
  logic            wr_op;
  logic            written;
  logic            in_fire;

  rvx_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rf_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // In the execute step the first operand sits in src_a_r, the second is still
  // held on read port 1 and the old destination value arrives on read port 0.
  rvx_alu u_alu (
    .func   (op_r.func),
    .src_a  (src_a_r),
    .src_b  (rdata1),
    .imm    (op_r.immediate),
    .result (alu_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Every code from add through clear updates the destination; nop and the
  // unused codes leave the file untouched.
  assign wr_op   = (op_r.func >= FN_ADD) && (op_r.func <= FN_CLEAR);
  assign written = wr_op && (op_r.dest_reg != '0);

  always_comb begin
    state_nxt     = state_r;
    exec_go       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    rf_req        = '0;
    rf_req.raddr0 = op_r.dest_reg;
    rf_req.raddr1 = in_data.src_b_reg;
    rf_req.waddr  = op_r.dest_reg;
    rf_req.wdata  = alu_res;
    case (state_r)
      S_IDLE: begin
        rf_req.raddr0 = in_data.src_a_reg;
        if (in_fire) begin
          rf_req.re0 = 1'b1;
          rf_req.re1 = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        rf_req.re0 = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          exec_go       = 1'b1;
          out_valid_nxt = 1'b1;
          // Clear-all drops every valid bit, which also zeroes the destination.
          rf_req.clr    = (op_r.func == FN_CLEAR);
          rf_req.we     = written && (op_r.func != FN_CLEAR);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_data;
    end
    if (state_r == S_READ) begin
      src_a_r <= rdata0;
    end
    if (exec_go) begin
      out_data_r.new_value <= written ? alu_res : rdata0;
      out_data_r.old_value <= rdata0;
      out_data_r.written   <= written;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RVX_ASSERT_NEXT(a_accept_reads, in_fire, state_r == S_READ, "accept did not start a read")
  `RVX_ASSERT_NOW(a_no_write_x0, rf_req.we, rf_req.waddr != '0, "write to register zero")
  `RVX_ASSERT_NEXT(a_exec_loads_out, exec_go, out_valid_r, "finished operation lost its result")
  `RVX_ASSERT_NOW(a_unwritten_same, out_valid_r && !out_data_r.written,
    out_data_r.new_value == out_data_r.old_value, "unwritten result changed value")

endmodule

// ----- src/rvx_regfile.sv -----
// 32 x 32-bit register file: two registered read ports, one write port, clear-all.
// Depends on rvx_pkg.
module rvx_regfile (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rvx_pkg::rf_req_t                req,
  output logic [rvx_pkg::XLEN-1:0]        rdata0,
  output logic [rvx_pkg::XLEN-1:0]        rdata1
);
  import rvx_pkg::*;

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [XLEN-1:0]     rdata0_r;
  logic [XLEN-1:0]     rdata1_r;

  // An entry that is not valid reads as zero; its memory word is not reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re0) begin
      rdata0_r <= vld_r[req.raddr0] ? mem[req.raddr0] : '0;
    end
    if (req.re1) begin
      rdata1_r <= vld_r[req.raddr1] ? mem[req.raddr1] : '0;
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ----- src/rvx_alu.sv -----
// Integer ALU for the register, immediate and move operations.
// Depends on rvx_pkg.
module rvx_alu (
  input  logic [4:0]                   func,
  input  logic [rvx_pkg::XLEN-1:0]     src_a,
  input  logic [rvx_pkg::XLEN-1:0]     src_b,
  input  logic [rvx_pkg::XLEN-1:0]     imm,
  output logic [rvx_pkg::XLEN-1:0]     result
);
  import rvx_pkg::*;

  logic [XLEN-1:0]    opb;
  logic [SHAMT_W-1:0] shamt;
  logic [2*XLEN-1:0]  prod;

  // Immediate forms take the immediate in place of the second register.
  assign opb   = (func >= FN_ADDI) ? imm : src_b;
  assign shamt = opb[SHAMT_W-1:0];
  assign prod  = src_a * src_b;

  always_comb begin
    case (func)
      FN_ADD, FN_ADDI:   result = src_a + opb;
      FN_SUB:            result = src_a - opb;
      FN_SLL, FN_SLLI:   result = src_a << shamt;
      FN_SLT, FN_SLTI:   result = {{(XLEN-1){1'b0}}, ($signed(src_a) < $signed(opb))};
      FN_SLTU, FN_SLTIU: result = {{(XLEN-1){1'b0}}, (src_a < opb)};
      FN_XOR, FN_XORI:   result = src_a ^ opb;
      FN_SRL, FN_SRLI:   result = src_a >> shamt;
      FN_SRA, FN_SRAI:   result = XLEN'($signed(src_a) >>> shamt);
      FN_OR, FN_ORI:     result = src_a | opb;
      FN_AND, FN_ANDI:   result = src_a & opb;
      FN_MUL:            result = prod[XLEN-1:0];
      FN_LUI:            result = {imm[XLEN-LUI_SHIFT-1:0], {LUI_SHIFT{1'b0}}};
      FN_LI:             result = imm;
      FN_MV:             result = src_a;
      default:           result = '0;
    endcase
  end

endmodule
